// ===== src/itbd_pkg.sv =====
// ----------------------------------------------------------------------------
// itbd_pkg: shared constants for the integer to base digits converter
// ASCII codes, radix limits and the digit to character mapping.
// ----------------------------------------------------------------------------
package itbd_pkg;

  localparam logic [5:0] RADIX_MIN     = 6'd2;
  localparam logic [5:0] RADIX_MAX     = 6'd36;
  localparam logic [5:0] DECIMAL_LIMIT = 6'd10;
  localparam logic [6:0] CH_ZERO       = 7'd48;
  localparam logic [6:0] CH_LOWER_A    = 7'd97;
  localparam logic [6:0] CH_MINUS      = 7'd45;

  // quotient bits resolved per divider cycle
  localparam int unsigned DIV_STEPS = 4;

  function automatic logic [6:0] char_of_digit(logic [5:0] d);
    logic [6:0] dd;
    dd = {1'b0, d};
    if (d < DECIMAL_LIMIT) begin
      return 7'(CH_ZERO + dd);
    end
    return 7'(CH_LOWER_A + dd - {1'b0, DECIMAL_LIMIT});
  endfunction

endpackage

// ===== src/itbd_ram.sv =====
// ----------------------------------------------------------------------------
// itbd_ram: generic simple dual port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module itbd_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/integer_to_base_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_base_digits: signed integer to ascii text in base 2..36
// Digits are found by repeated division of the magnitude, stored least
// significant first, then emitted most significant first, a negative value with a leading '-'.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                                   | tlast     | tuser
//  ---------+-----+-----------------------------------------+-----------+----------
//  s_axis   | in  | value [VALUE_BITS-1:0], radix [5:0]     | -         | -
//  m_axis   | out | char_code [6:0]                         | last_char | bad_radix
//
//  a valid item is divided once per digit, four quotient bits per divider cycle;
//  it takes one sign slot whether or not a minus is sent, and a ram read plus
//  an emit per character
//  a bad radix item goes to S_BAD, which registers its result once the output is free
//  s_axis_tready_o is high only between items; a stalled output holds the
//  sequencer in its sign, emit or error state; reset clears the sequencer and outputs
//
module integer_to_base_digits #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // value [VALUE_BITS-1:0], radix [VALUE_BITS+5:VALUE_BITS], zero fill
  input  logic [((VALUE_BITS+6+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // char_code [6:0], zero fill
  output logic [7:0]            m_axis_tdata_o,
  output logic                  m_axis_tlast_o,
  // bad_radix [0]
  output logic                  m_axis_tuser_o
);

  localparam int unsigned STEPS      = itbd_pkg::DIV_STEPS;
  localparam int unsigned WORK_BITS  = ((VALUE_BITS + STEPS - 1) / STEPS) * STEPS;
  localparam int unsigned DIV_CYCLES = WORK_BITS / STEPS;
  localparam int unsigned BC_W       = $clog2(DIV_CYCLES);
  localparam int unsigned AW         = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_RD,
    S_OUT,
    S_BAD
  } state_e;

  state_e               state_q, state_d;
  logic [WORK_BITS-1:0] work_q, work_d;
  logic [5:0]           rem_q, rem_d;
  logic [5:0]           radix_q, radix_d;
  logic [BC_W-1:0]      bitcnt_q, bitcnt_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [AW-1:0]        rd_idx_q, rd_idx_d;
  logic                 neg_q, neg_d;
  logic                 m_valid_q, m_valid_d;
  logic [6:0]           m_char_q, m_char_d;
  logic                 m_last_q, m_last_d;
  logic                 m_bad_q, m_bad_d;

  logic [VALUE_BITS-1:0] value_in;
  logic [5:0]            radix_in;
  logic                  radix_bad;
  logic                  value_neg;
  logic [VALUE_BITS-1:0] value_mag;
  logic                  out_free;
  logic                  div_last;

  logic [WORK_BITS-1:0]  work_step;
  logic [5:0]            rem_step;

  logic                  ram_we;
  logic [5:0]            ram_rdata;

  assign value_in  = s_axis_tdata_i[VALUE_BITS-1:0];
  assign radix_in  = s_axis_tdata_i[VALUE_BITS+5:VALUE_BITS];
  assign radix_bad = (radix_in < itbd_pkg::RADIX_MIN) || (radix_in > itbd_pkg::RADIX_MAX);
  assign value_neg = value_in[VALUE_BITS-1];
  assign value_mag = value_neg ? VALUE_BITS'(~value_in + 1'b1) : value_in;
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign div_last  = (bitcnt_q == BC_W'(DIV_CYCLES - 1));
  assign ram_we    = (state_q == S_DIV) && div_last;

  // shared restoring divider slice: dividend bits leave the top, quotient
  // bits enter at the bottom
  always_comb begin
    logic [WORK_BITS-1:0] w;
    logic [5:0]           r;
    logic [6:0]           t;
    w = work_q;
    r = rem_q;
    for (int k = 0; k < STEPS; k++) begin
      t = {r, w[WORK_BITS-1]};
      w = {w[WORK_BITS-2:0], 1'b0};
      if (t >= {1'b0, radix_q}) begin
        t    = t - {1'b0, radix_q};
        w[0] = 1'b1;
      end
      r = t[5:0];
    end
    work_step = w;
    rem_step  = r;
  end

  always_comb begin
    state_d   = state_q;
    work_d    = work_q;
    rem_d     = rem_q;
    radix_d   = radix_q;
    bitcnt_d  = bitcnt_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    neg_d     = neg_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_char_d  = m_char_q;
    m_last_d  = m_last_q;
    m_bad_d   = m_bad_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (radix_bad) begin
            state_d = S_BAD;
          end else begin
            work_d   = WORK_BITS'(value_mag);
            rem_d    = '0;
            radix_d  = radix_in;
            bitcnt_d = '0;
            count_d  = '0;
            neg_d    = value_neg;
            state_d  = S_DIV;
          end
        end
      end
      S_DIV: begin
        work_d   = work_step;
        rem_d    = rem_step;
        bitcnt_d = BC_W'(bitcnt_q + 1'b1);
        if (div_last) begin
          // digit is written this cycle at count_q
          count_d  = CNT_W'(count_q + 1'b1);
          rd_idx_d = count_q[AW-1:0];
          rem_d    = '0;
          bitcnt_d = '0;
          if (work_step == '0) begin
            state_d = S_SIGN;
          end
        end
      end
      S_SIGN: begin
        if (!neg_q) begin
          state_d = S_RD;
        end else if (out_free) begin
          m_valid_d = 1'b1;
          m_char_d  = itbd_pkg::CH_MINUS;
          m_last_d  = 1'b0;
          m_bad_d   = 1'b0;
          state_d   = S_RD;
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_char_d  = itbd_pkg::char_of_digit(ram_rdata);
          m_last_d  = (rd_idx_q == '0);
          m_bad_d   = 1'b0;
          if (rd_idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rd_idx_d = AW'(rd_idx_q - 1'b1);
            state_d  = S_RD;
          end
        end
      end
      S_BAD: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_char_d  = '0;
          m_last_d  = 1'b1;
          m_bad_d   = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bitcnt_q  <= '0;
      count_q   <= '0;
      rd_idx_q  <= '0;
      neg_q     <= 1'b0;
      m_valid_q <= 1'b0;
      work_q    <= '0;
      rem_q     <= '0;
      radix_q   <= '0;
      m_char_q  <= '0;
      m_last_q  <= 1'b0;
      m_bad_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      bitcnt_q  <= bitcnt_d;
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      neg_q     <= neg_d;
      m_valid_q <= m_valid_d;
      work_q    <= work_d;
      rem_q     <= rem_d;
      radix_q   <= radix_d;
      m_char_q  <= m_char_d;
      m_last_q  <= m_last_d;
      m_bad_q   <= m_bad_d;
    end
  end

  itbd_ram #(
    .WIDTH (6),
    .DEPTH (VALUE_BITS)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (rem_step),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_char_q};
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_bad_q;

  // a bad radix item goes straight to its error result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && radix_bad) |=> (state_q == S_BAD))
    else $error("bad radix item did not take the error path");

  // an error result is the whole conversion and carries a zero code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tlast_o && m_axis_tdata_o == 8'd0))
    else $error("error result not flagged last or code not zero");

  // the digit store never runs past its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (count_q < CNT_W'(VALUE_BITS)))
    else $error("digit count overran the digit store");

  // the remainder stays below the base
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < radix_q))
    else $error("remainder reached the radix");

endmodule
